// ----- design/v3alu_pkg.sv -----
// v3alu_pkg: widths, codes and types shared by the vector ALU files
// no dependencies; used by v3alu_sqrt_pipe and vec3_alu_unit
`timescale 1ns / 1ps
`default_nettype none

package v3alu_pkg;

  // number format
  localparam int CW     = 24;              // component width
  localparam int FB     = 16;              // fraction bits
  localparam int DOT_W  = 2 * CW - FB + 1; // rounded dot product width

  // internal widths
  localparam int OP_W   = CW + 1;          // multiplier operand (holds 1.0 - s)
  localparam int PW     = 2 * OP_W;        // multiplier product
  localparam int SUM_W  = PW + 1;          // sum of two products
  localparam int DSUM_W = 2 * CW + 2;      // exact sum of three a*b products
  localparam int SQ_W   = 2 * CW;          // sum of three squares
  localparam int RT_W   = CW + 1;          // rounded square root
  localparam int QB     = FB + 1;          // normalise quotient bits
  localparam int NUM_W  = CW + FB;         // |a_i| scaled by one
  localparam int DIVD_W = NUM_W + 2;       // 2n + m
  localparam int DVS_W  = RT_W + 1;        // 2m

  // pipeline shape
  localparam int SQRT_LAT    = CW + 1;
  localparam int PIPE_STAGES = 4 + SQRT_LAT + 1 + QB + 1 + 2 + SQRT_LAT;

  // stream packing
  localparam int IN_BITS  = 4 + 7 * CW;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 4 * CW + DOT_W + 1 + 2;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // operation codes
  localparam logic [3:0] ACT_ADD   = 4'd0;
  localparam logic [3:0] ACT_SUB   = 4'd1;
  localparam logic [3:0] ACT_SCALE = 4'd2;
  localparam logic [3:0] ACT_DOT   = 4'd3;
  localparam logic [3:0] ACT_CROSS = 4'd4;
  localparam logic [3:0] ACT_MAX   = 4'd5;
  localparam logic [3:0] ACT_COLIN = 4'd6;
  localparam logic [3:0] ACT_NORM  = 4'd7;
  localparam logic [3:0] ACT_LERP  = 4'd8;
  localparam logic [3:0] ACT_MAG   = 4'd9;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef logic signed [CW-1:0]     comp_t;
  typedef logic signed [OP_W-1:0]   op_t;
  typedef logic signed [PW-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]  wide_t;
  typedef logic signed [DSUM_W-1:0] dsum_t;
  typedef logic [SQ_W-1:0]          sq_t;
  typedef logic [RT_W-1:0]          root_t;

  // per-item record carried down the pipeline
  typedef struct packed {
    logic [3:0]               act;
    comp_t [2:0]              a;
    comp_t [2:0]              r;
    logic signed [DOT_W-1:0]  dot;
    logic                     flag;
    logic [1:0]               status;
    logic                     zero;
  } info_t;

endpackage

`default_nettype wire

// ----- design/vec3_alu_unit.sv -----
// Usage: three-component fixed point vector ALU on a stream.
// One input beat on in_t* carries an operation code, two Q8.16 vectors and a
// scalar; exactly one result beat follows on out_t* with the result vector,
// its magnitude, the dot product of the inputs, a flag and a status.
// Throughput: one beat per cycle, sustained while the receiver takes results.
// The pipeline runs through two 25-stage square root pipelines (normalise
// length, result magnitude) and a 17-stage restoring divider for normalise;
// every operation takes the same path so results leave in order.
// Reset (rst_n low, synchronous) empties the pipeline and the output register.
// When the receiver stalls, the result waits in the output register and the
// pipeline keeps moving until an item reaches its last stage; only then does
// the whole pipeline hold and in_tready fall. Nothing is dropped or repeated.
// depends on v3alu_pkg and v3alu_sqrt_pipe
`timescale 1ns / 1ps
`default_nettype none

module vec3_alu_unit (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  // action[3:0], a_x, a_y, a_z, b_x, b_y, b_z, scalar_in (24 each), zero pad
  input  wire [v3alu_pkg::IN_W-1:0]      in_tdata,
  output logic                           out_tvalid,
  input  wire                            out_tready,
  // r_x, r_y, r_z, r_mag (24 each), dot_out (33), flag, status (2), zero pad
  output logic [v3alu_pkg::OUT_W-1:0]    out_tdata
);

  localparam int CW    = v3alu_pkg::CW;
  localparam int FB    = v3alu_pkg::FB;
  localparam int DOT_W = v3alu_pkg::DOT_W;
  localparam int SQ_W  = v3alu_pkg::SQ_W;
  localparam int QB    = v3alu_pkg::QB;
  localparam int DIVD_W = v3alu_pkg::DIVD_W;
  localparam int DVS_W = v3alu_pkg::DVS_W;
  localparam int SUM_W = v3alu_pkg::SUM_W;
  localparam int NST   = v3alu_pkg::PIPE_STAGES;
  localparam int SL    = v3alu_pkg::SQRT_LAT;
  localparam int OUT_W = v3alu_pkg::OUT_W;
  localparam int OUT_BITS = v3alu_pkg::OUT_BITS;

  localparam v3alu_pkg::op_t   FX_ONE = v3alu_pkg::op_t'(1) << FB;
  localparam v3alu_pkg::wide_t HALF   = v3alu_pkg::wide_t'(1) << (FB - 1);
  localparam v3alu_pkg::dsum_t DHALF  = v3alu_pkg::dsum_t'(1) << (FB - 1);
  localparam v3alu_pkg::wide_t W_MAX  = {{(SUM_W - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
  localparam v3alu_pkg::wide_t W_MIN  = ~W_MAX;

  function automatic v3alu_pkg::comp_t sat_c(input v3alu_pkg::wide_t v);
    if (v > W_MAX) begin
      return W_MAX[CW-1:0];
    end else if (v < W_MIN) begin
      return W_MIN[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

  function automatic logic ovf(input v3alu_pkg::wide_t v);
    return (v > W_MAX) || (v < W_MIN);
  endfunction

  // ---------------------------------------------------------------- flow control
  logic [NST-1:0] vld_r;
  logic           out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic           out_free;
  logic           en;

  assign out_free  = !out_valid_r || out_tready;
  assign en        = out_free || !vld_r[NST-1];
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  // ---------------------------------------------------------------- stage 1: operand select
  logic [3:0]          act_in;
  v3alu_pkg::comp_t    a_in [3];
  v3alu_pkg::comp_t    b_in [3];
  v3alu_pkg::comp_t    s_in;
  v3alu_pkg::op_t      w_in;
  v3alu_pkg::op_t      opx_nxt [6];
  v3alu_pkg::op_t      opy_nxt [6];
  v3alu_pkg::op_t      opx_r [6];
  v3alu_pkg::op_t      opy_r [6];
  v3alu_pkg::comp_t    a1_r [3];
  v3alu_pkg::comp_t    b1_r [3];
  logic [3:0]          act1_r;

  always_comb begin
    act_in = in_tdata[3:0];
    for (int i = 0; i < 3; i++) begin
      a_in[i] = in_tdata[4 + i * CW +: CW];
      b_in[i] = in_tdata[4 + (3 + i) * CW +: CW];
    end
    s_in = in_tdata[4 + 6 * CW +: CW];
    w_in = FX_ONE - v3alu_pkg::op_t'(s_in);
  end

  // six shared multipliers; pairs i and i+3 feed result component i
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      opx_nxt[k] = '0;
      opy_nxt[k] = '0;
    end
    case (act_in)
      v3alu_pkg::ACT_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          opx_nxt[i] = v3alu_pkg::op_t'(a_in[i]);
          opy_nxt[i] = v3alu_pkg::op_t'(s_in);
        end
      end
      v3alu_pkg::ACT_CROSS, v3alu_pkg::ACT_COLIN: begin
        opx_nxt[0] = v3alu_pkg::op_t'(a_in[1]); opy_nxt[0] = v3alu_pkg::op_t'(b_in[2]);
        opx_nxt[3] = v3alu_pkg::op_t'(a_in[2]); opy_nxt[3] = v3alu_pkg::op_t'(b_in[1]);
        opx_nxt[1] = v3alu_pkg::op_t'(a_in[2]); opy_nxt[1] = v3alu_pkg::op_t'(b_in[0]);
        opx_nxt[4] = v3alu_pkg::op_t'(a_in[0]); opy_nxt[4] = v3alu_pkg::op_t'(b_in[2]);
        opx_nxt[2] = v3alu_pkg::op_t'(a_in[0]); opy_nxt[2] = v3alu_pkg::op_t'(b_in[1]);
        opx_nxt[5] = v3alu_pkg::op_t'(a_in[1]); opy_nxt[5] = v3alu_pkg::op_t'(b_in[0]);
      end
      v3alu_pkg::ACT_MAX: begin
        for (int i = 0; i < 3; i++) begin
          opx_nxt[i]     = v3alu_pkg::op_t'(a_in[i]);
          opy_nxt[i]     = v3alu_pkg::op_t'(a_in[i]);
          opx_nxt[i + 3] = v3alu_pkg::op_t'(b_in[i]);
          opy_nxt[i + 3] = v3alu_pkg::op_t'(b_in[i]);
        end
      end
      v3alu_pkg::ACT_NORM: begin
        for (int i = 0; i < 3; i++) begin
          opx_nxt[i] = v3alu_pkg::op_t'(a_in[i]);
          opy_nxt[i] = v3alu_pkg::op_t'(a_in[i]);
        end
      end
      v3alu_pkg::ACT_LERP: begin
        for (int i = 0; i < 3; i++) begin
          opx_nxt[i]     = v3alu_pkg::op_t'(a_in[i]);
          opy_nxt[i]     = w_in;
          opx_nxt[i + 3] = v3alu_pkg::op_t'(b_in[i]);
          opy_nxt[i + 3] = v3alu_pkg::op_t'(s_in);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      opx_r  <= opx_nxt;
      opy_r  <= opy_nxt;
      a1_r   <= a_in;
      b1_r   <= b_in;
      act1_r <= act_in;
    end
  end

  // ---------------------------------------------------------------- stage 2: products
  v3alu_pkg::prod_t         prod_r [6];
  logic signed [2*CW-1:0]   tdot_r [3];
  v3alu_pkg::comp_t         a2_r [3];
  v3alu_pkg::comp_t         b2_r [3];
  logic [3:0]               act2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        prod_r[k] <= opx_r[k] * opy_r[k];
      end
      for (int i = 0; i < 3; i++) begin
        tdot_r[i] <= a1_r[i] * b1_r[i];
      end
      a2_r   <= a1_r;
      b2_r   <= b1_r;
      act2_r <= act1_r;
    end
  end

  // ---------------------------------------------------------------- stage 3: exact sums
  v3alu_pkg::wide_t   comb_nxt [3];
  v3alu_pkg::wide_t   comb_r [3];
  v3alu_pkg::dsum_t   dsum_r;
  v3alu_pkg::sq_t     sqa_r;
  v3alu_pkg::sq_t     sqb_r;
  logic               eq3_r;
  v3alu_pkg::comp_t   a3_r [3];
  v3alu_pkg::comp_t   b3_r [3];
  logic [3:0]         act3_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (act2_r == v3alu_pkg::ACT_CROSS || act2_r == v3alu_pkg::ACT_COLIN) begin
        comb_nxt[i] = v3alu_pkg::wide_t'(prod_r[i]) - v3alu_pkg::wide_t'(prod_r[i + 3]);
      end else begin
        comb_nxt[i] = v3alu_pkg::wide_t'(prod_r[i]) + v3alu_pkg::wide_t'(prod_r[i + 3]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      comb_r <= comb_nxt;
      dsum_r <= v3alu_pkg::dsum_t'(tdot_r[0]) + v3alu_pkg::dsum_t'(tdot_r[1]) +
                v3alu_pkg::dsum_t'(tdot_r[2]);
      sqa_r  <= v3alu_pkg::sq_t'(prod_r[0] + prod_r[1] + prod_r[2]);
      sqb_r  <= v3alu_pkg::sq_t'(prod_r[3] + prod_r[4] + prod_r[5]);
      eq3_r  <= (prod_r[0] == prod_r[3]) && (prod_r[1] == prod_r[4]) &&
                (prod_r[2] == prod_r[5]);
      a3_r   <= a2_r;
      b3_r   <= b2_r;
      act3_r <= act2_r;
    end
  end

  // ---------------------------------------------------------------- stage 4: round, saturate, select
  v3alu_pkg::info_t  info4_nxt;
  v3alu_pkg::info_t  info4_r;
  v3alu_pkg::sq_t    sq4_r;
  v3alu_pkg::wide_t  rnd4 [3];
  v3alu_pkg::wide_t  addv4 [3];
  v3alu_pkg::wide_t  subv4 [3];
  logic              hit4;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd4[i]  = (comb_r[i] + HALF) >>> FB;
      addv4[i] = v3alu_pkg::wide_t'(a3_r[i]) + v3alu_pkg::wide_t'(b3_r[i]);
      subv4[i] = v3alu_pkg::wide_t'(a3_r[i]) - v3alu_pkg::wide_t'(b3_r[i]);
    end
    hit4            = 1'b0;
    info4_nxt       = '0;
    info4_nxt.act   = act3_r;
    info4_nxt.dot   = DOT_W'((dsum_r + DHALF) >>> FB);
    info4_nxt.zero  = (sqa_r == '0);
    for (int i = 0; i < 3; i++) begin
      info4_nxt.a[i] = a3_r[i];
    end
    case (act3_r)
      v3alu_pkg::ACT_ADD: begin
        for (int i = 0; i < 3; i++) begin
          info4_nxt.r[i] = sat_c(addv4[i]);
          hit4 = hit4 | ovf(addv4[i]);
        end
      end
      v3alu_pkg::ACT_SUB: begin
        for (int i = 0; i < 3; i++) begin
          info4_nxt.r[i] = sat_c(subv4[i]);
          hit4 = hit4 | ovf(subv4[i]);
        end
      end
      v3alu_pkg::ACT_SCALE, v3alu_pkg::ACT_CROSS, v3alu_pkg::ACT_LERP: begin
        for (int i = 0; i < 3; i++) begin
          info4_nxt.r[i] = sat_c(rnd4[i]);
          hit4 = hit4 | ovf(rnd4[i]);
        end
      end
      v3alu_pkg::ACT_MAX: begin
        // tie keeps a
        info4_nxt.flag = (sqa_r < sqb_r);
        for (int i = 0; i < 3; i++) begin
          info4_nxt.r[i] = (sqa_r < sqb_r) ? b3_r[i] : a3_r[i];
        end
      end
      v3alu_pkg::ACT_COLIN: begin
        info4_nxt.flag = eq3_r && !dsum_r[v3alu_pkg::DSUM_W-1];
      end
      v3alu_pkg::ACT_NORM: begin
        // quotient filled in after the divider
        if (sqa_r == '0) begin
          info4_nxt.status = v3alu_pkg::ST_ZERO;
        end
      end
      v3alu_pkg::ACT_MAG: begin
        for (int i = 0; i < 3; i++) begin
          info4_nxt.r[i] = a3_r[i];
        end
      end
      default: begin
      end
    endcase
    if (hit4) begin
      info4_nxt.status = v3alu_pkg::ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      info4_r <= info4_nxt;
      sq4_r   <= sqa_r;
    end
  end

  // ---------------------------------------------------------------- length of a for normalise
  v3alu_pkg::root_t root_a;
  v3alu_pkg::info_t inf_a_r [SL];

  v3alu_sqrt_pipe u_sqrt_a (
    .clk      (clk),
    .en       (en),
    .sq_in    (sq4_r),
    .root_out (root_a)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      inf_a_r[0] <= info4_r;
      for (int k = 1; k < SL; k++) begin
        inf_a_r[k] <= inf_a_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- divider set-up: (2n + m) / 2m
  logic [DIVD_W-1:0]  dvd_nxt [3];
  logic [2:0]         neg_nxt;
  logic [DIVD_W-1:0]  dvd0_r [3];
  logic [DVS_W-1:0]   dvs0_r;
  logic [2:0]         neg0_r;
  v3alu_pkg::info_t   infd0_r;
  v3alu_pkg::comp_t   an_c [3];
  logic signed [CW:0] an_ext [3];
  logic signed [CW:0] an_abs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      an_c[i]    = v3alu_pkg::comp_t'(inf_a_r[SL-1].a[i]);
      an_ext[i]  = {an_c[i][CW-1], an_c[i]};
      an_abs[i]  = an_ext[i][CW] ? -an_ext[i] : an_ext[i];
      neg_nxt[i] = an_c[i][CW-1];
      dvd_nxt[i] = DIVD_W'({an_abs[i][CW-1:0], {FB{1'b0}}, 1'b0}) + DIVD_W'(root_a);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvd0_r  <= dvd_nxt;
      dvs0_r  <= {root_a, 1'b0};
      neg0_r  <= neg_nxt;
      infd0_r <= inf_a_r[SL-1];
    end
  end

  // ---------------------------------------------------------------- restoring divider, one quotient bit per stage
  logic [DIVD_W-1:0]  drem_r [QB][3];
  logic [QB-1:0]      dq_r   [QB][3];
  logic [DVS_W-1:0]   ddvs_r [QB];
  logic [2:0]         dneg_r [QB];
  v3alu_pkg::info_t   dinf_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int BB = QB - 1 - k;
    logic [DIVD_W-1:0] rem_in [3];
    logic [QB-1:0]     q_in [3];
    logic [DVS_W-1:0]  dvs_in;
    logic [2:0]        neg_in;
    v3alu_pkg::info_t  inf_in;
    logic [DIVD_W-1:0] shd;

    if (k == 0) begin : g_head
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = dvd0_r[i];
          q_in[i]   = '0;
        end
      end
      assign dvs_in = dvs0_r;
      assign neg_in = neg0_r;
      assign inf_in = infd0_r;
    end else begin : g_tail
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = drem_r[k-1][i];
          q_in[i]   = dq_r[k-1][i];
        end
      end
      assign dvs_in = ddvs_r[k-1];
      assign neg_in = dneg_r[k-1];
      assign inf_in = dinf_r[k-1];
    end

    assign shd = DIVD_W'(dvs_in) << BB;

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (rem_in[i] >= shd) begin
            drem_r[k][i] <= rem_in[i] - shd;
            dq_r[k][i]   <= q_in[i] | (QB'(1) << BB);
          end else begin
            drem_r[k][i] <= rem_in[i];
            dq_r[k][i]   <= q_in[i];
          end
        end
        ddvs_r[k] <= dvs_in;
        dneg_r[k] <= neg_in;
        dinf_r[k] <= inf_in;
      end
    end
  end

  // ---------------------------------------------------------------- final result vector
  v3alu_pkg::info_t  sel_nxt;
  v3alu_pkg::info_t  inf5_r;
  v3alu_pkg::wide_t  qv [3];
  logic              hit5;

  always_comb begin
    sel_nxt = dinf_r[QB-1];
    hit5    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      qv[i] = v3alu_pkg::wide_t'(dq_r[QB-1][i]);
      if (dneg_r[QB-1][i]) begin
        qv[i] = -qv[i];
      end
    end
    if (sel_nxt.act == v3alu_pkg::ACT_NORM && !sel_nxt.zero) begin
      for (int i = 0; i < 3; i++) begin
        sel_nxt.r[i] = sat_c(qv[i]);
        hit5 = hit5 | ovf(qv[i]);
      end
      if (hit5) begin
        sel_nxt.status = v3alu_pkg::ST_SAT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inf5_r <= sel_nxt;
    end
  end

  // ---------------------------------------------------------------- squares and sum of the result
  logic signed [SQ_W-1:0] sqr_nxt [3];
  logic signed [SQ_W-1:0] sqr_r [3];
  v3alu_pkg::info_t       inf6_r;
  v3alu_pkg::info_t       inf7_r;
  v3alu_pkg::sq_t         sq7_r;
  v3alu_pkg::comp_t       rc5 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rc5[i]     = v3alu_pkg::comp_t'(inf5_r.r[i]);
      sqr_nxt[i] = rc5[i] * rc5[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqr_r  <= sqr_nxt;
      inf6_r <= inf5_r;
      sq7_r  <= v3alu_pkg::sq_t'(sqr_r[0]) + v3alu_pkg::sq_t'(sqr_r[1]) +
                v3alu_pkg::sq_t'(sqr_r[2]);
      inf7_r <= inf6_r;
    end
  end

  // ---------------------------------------------------------------- magnitude of the result
  v3alu_pkg::root_t root_m;
  v3alu_pkg::info_t inf_b_r [SL];

  v3alu_sqrt_pipe u_sqrt_r (
    .clk      (clk),
    .en       (en),
    .sq_in    (sq7_r),
    .root_out (root_m)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      inf_b_r[0] <= inf7_r;
      for (int k = 1; k < SL; k++) begin
        inf_b_r[k] <= inf_b_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= vld_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= {{(OUT_W - OUT_BITS){1'b0}},
                     inf_b_r[SL-1].status,
                     inf_b_r[SL-1].flag,
                     inf_b_r[SL-1].dot,
                     root_m[CW-1:0],
                     inf_b_r[SL-1].r[2],
                     inf_b_r[SL-1].r[1],
                     inf_b_r[SL-1].r[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  // a frozen pipeline keeps its valid bits
  a_frozen_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valid bits moved while frozen");

  // an item in the last stage lands in a free output register
  a_last_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (out_free && vld_r[NST-1]) |=> out_valid_r)
    else $error("last stage item not moved to output");

  // normalise of a zero vector gives a zero vector and zero length
  a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[OUT_BITS-1 -: 2] == v3alu_pkg::ST_ZERO) |->
    (out_data_r[4*CW-1:0] == '0))
    else $error("zero-vector status with non-zero result");
`endif

endmodule

`default_nettype wire

// ----- design/v3alu_sqrt_pipe.sv -----
// v3alu_sqrt_pipe: pipelined square root rounded to nearest, one root bit per stage
// depends on v3alu_pkg (widths and types)
`timescale 1ns / 1ps
`default_nettype none

module v3alu_sqrt_pipe (
  input  wire                   clk,
  input  wire                   en,
  input  wire v3alu_pkg::sq_t   sq_in,
  output v3alu_pkg::root_t      root_out
);

  localparam int NB   = v3alu_pkg::CW;
  localparam int SQ_W = v3alu_pkg::SQ_W;
  localparam int RT_W = v3alu_pkg::RT_W;

  v3alu_pkg::sq_t  rem_r  [NB];
  logic [NB-1:0]   root_r [NB];
  v3alu_pkg::root_t root_out_r;

  // one stage per root bit, msb first; rem holds s - root^2
  for (genvar j = 0; j < NB; j++) begin : g_iter
    localparam int BI = NB - 1 - j;
    logic [SQ_W:0]  rem_in;
    logic [SQ_W:0]  term;
    logic [NB-1:0]  root_in;

    if (j == 0) begin : g_head
      assign rem_in  = {1'b0, sq_in};
      assign root_in = '0;
    end else begin : g_tail
      assign rem_in  = {1'b0, rem_r[j-1]};
      assign root_in = root_r[j-1];
    end

    // (root + 2^bi)^2 - root^2
    assign term = ({{(NB + 1){1'b0}}, root_in} << (BI + 1)) |
                  ((SQ_W + 1)'(1) << (2 * BI));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= term) begin
          rem_r[j]  <= SQ_W'(rem_in - term);
          root_r[j] <= root_in | (NB'(1) << BI);
        end else begin
          rem_r[j]  <= rem_in[SQ_W-1:0];
          root_r[j] <= root_in;
        end
      end
    end
  end

  // round up when the remainder exceeds the root
  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_r[NB-1] > SQ_W'(root_r[NB-1])) begin
        root_out_r <= RT_W'(root_r[NB-1]) + RT_W'(1);
      end else begin
        root_out_r <= RT_W'(root_r[NB-1]);
      end
    end
  end

  assign root_out = root_out_r;

endmodule

`default_nettype wire
